@@ rtl/jkim_pkg.sv @@
package jkim_pkg;

   localparam int CODE_W    = 7;
   localparam int JOY_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 8;

   typedef enum logic [1:0] {
      OP_KEY_EVENT  = 2'd0,
      OP_FRAME_TICK = 2'd1,
      OP_KEY_QUERY  = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UP_KEY     = 3'd0,
      CSR_DOWN_KEY   = 3'd1,
      CSR_LEFT_KEY   = 3'd2,
      CSR_RIGHT_KEY  = 3'd3,
      CSR_FIRE_KEY_A = 3'd4,
      CSR_FIRE_KEY_B = 3'd5,
      CSR_RSVD_6     = 3'd6,
      CSR_RSVD_7     = 3'd7
   } csr_idx_type;

   localparam logic [CODE_W-1:0] UP_KEY_RST     = 7'd76;
   localparam logic [CODE_W-1:0] DOWN_KEY_RST   = 7'd77;
   localparam logic [CODE_W-1:0] LEFT_KEY_RST   = 7'd79;
   localparam logic [CODE_W-1:0] RIGHT_KEY_RST  = 7'd78;
   localparam logic [CODE_W-1:0] FIRE_KEY_A_RST = 7'd64;
   localparam logic [CODE_W-1:0] FIRE_KEY_B_RST = 7'd68;

   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   typedef struct packed {
      logic [REQ_W-CODE_W-JOY_W-3:0] pad;
      logic                          fire_pin;
      logic [JOY_W-1:0]              joy_word;
      logic                          key_released;
      logic [CODE_W-1:0]             key_code;
   } req_data_type;

   typedef struct packed {
      logic       key_pressed;
      logic       any_held;
      logic       fire_pressed;
      logic       fire_held;
      logic [1:0] dir_y;
      logic [1:0] dir_x;
   } rsp_data_type;

endpackage

@@ rtl/joystick_keyboard_input_merge.sv @@
// Merges key events and a joystick sample into per-frame direction and fire
// status. Requests carry a kind in req_tuser: a key event updates the held-key
// table and gives no response, a frame tick latches the held table as the
// current snapshot and returns dir_x, dir_y, fire and any-held, and a key query
// returns whether that key was newly pressed between the last two ticks.
// Each request is registered, resolved in combinational logic and lands in the
// response register (one request per clock while the response side keeps up).
// The user must write key remaps on the csr_ port only while no request is in
// flight; the block itself does not enforce this.
module joystick_keyboard_input_merge #(
   parameter int KEY_COUNT = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key_code[6:0], key_released[7], joy_word[23:8], fire_pin[24], zero[31:25]
   input  logic [jkim_pkg::REQ_W-1:0]       req_tdata,
   // opcode[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // dir_x[1:0], dir_y[3:2], fire_held[4], fire_pressed[5], any_held[6],
   // key_pressed[7]
   output logic [jkim_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_we,
   input  logic [jkim_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jkim_pkg::CODE_W-1:0]      csr_wdata
);
   import jkim_pkg::*;

   localparam int IDX_W  = $clog2(KEY_COUNT);
   localparam int WIDE_W = ((IDX_W > CODE_W) ? IDX_W : CODE_W) + 1;

   logic [CODE_W-1:0]    up_code_ff, down_code_ff, left_code_ff, right_code_ff;
   logic [CODE_W-1:0]    fire_a_code_ff, fire_b_code_ff;

   logic                 req_valid_ff;
   op_type               req_op_ff;
   req_data_type         req_ff;

   logic [KEY_COUNT-1:0] held_ff, held_in;
   logic [KEY_COUNT-1:0] cur_ff, prev_ff;
   logic                 fire_now_ff, fire_in;

   logic                 rsp_valid_ff;
   rsp_data_type         rsp_ff, rsp_in;

   logic                 has_rsp, out_free, stage_go;
   logic                 key_ok;
   logic [IDX_W-1:0]     key_idx;
   logic                 up_h, down_h, left_h, right_h, fire_key_h;
   logic [1:0]           dx, dy;

   function automatic logic code_ok(input logic [CODE_W-1:0] code);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(code);
      return wide < WIDE_W'(KEY_COUNT);
   endfunction

   function automatic logic [IDX_W-1:0] code_idx(input logic [CODE_W-1:0] code);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(code);
      return wide[IDX_W-1:0];
   endfunction

   function automatic logic is_held(input logic [KEY_COUNT-1:0] tbl,
                                    input logic [CODE_W-1:0]    code);
      return code_ok(code) && tbl[code_idx(code)];
   endfunction

   assign has_rsp    = (req_op_ff == OP_FRAME_TICK) || (req_op_ff == OP_KEY_QUERY);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_go   = req_valid_ff && (!has_rsp || out_free);
   assign req_tready = !req_valid_ff || stage_go;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign key_ok  = code_ok(req_ff.key_code);
   assign key_idx = code_idx(req_ff.key_code);

   assign up_h       = is_held(held_ff, up_code_ff);
   assign down_h     = is_held(held_ff, down_code_ff);
   assign left_h     = is_held(held_ff, left_code_ff);
   assign right_h    = is_held(held_ff, right_code_ff);
   assign fire_key_h = is_held(held_ff, fire_a_code_ff) || is_held(held_ff, fire_b_code_ff);

   always_comb begin
      dx = DIR_NONE;
      if (req_ff.joy_word[1]) dx = DIR_POS;
      if (req_ff.joy_word[9]) dx = DIR_NEG;
      if (left_h)             dx = DIR_NEG;
      if (right_h)            dx = DIR_POS;

      dy = DIR_NONE;
      if (req_ff.joy_word[1] ^ req_ff.joy_word[0]) dy = DIR_POS;
      if (req_ff.joy_word[9] ^ req_ff.joy_word[8]) dy = DIR_NEG;
      if (up_h)                                    dy = DIR_NEG;
      if (down_h)                                  dy = DIR_POS;
   end

   assign fire_in = !req_ff.fire_pin || fire_key_h;

   always_comb begin
      held_in = held_ff;
      if (req_op_ff == OP_KEY_EVENT && key_ok) begin
         held_in[key_idx] = !req_ff.key_released;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_op_ff)
         OP_FRAME_TICK: begin
            rsp_in.dir_x        = dx;
            rsp_in.dir_y        = dy;
            rsp_in.fire_held    = fire_in;
            rsp_in.fire_pressed = fire_in && !fire_now_ff;
            rsp_in.any_held     = |held_ff;
         end
         OP_KEY_QUERY: begin
            rsp_in.key_pressed  = key_ok && cur_ff[key_idx] && !prev_ff[key_idx];
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_code_ff     <= UP_KEY_RST;
         down_code_ff   <= DOWN_KEY_RST;
         left_code_ff   <= LEFT_KEY_RST;
         right_code_ff  <= RIGHT_KEY_RST;
         fire_a_code_ff <= FIRE_KEY_A_RST;
         fire_b_code_ff <= FIRE_KEY_B_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_UP_KEY:     up_code_ff     <= csr_wdata;
            CSR_DOWN_KEY:   down_code_ff   <= csr_wdata;
            CSR_LEFT_KEY:   left_code_ff   <= csr_wdata;
            CSR_RIGHT_KEY:  right_code_ff  <= csr_wdata;
            CSR_FIRE_KEY_A: fire_a_code_ff <= csr_wdata;
            CSR_FIRE_KEY_B: fire_b_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         req_op_ff    <= OP_UNUSED;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
         req_op_ff    <= op_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_ff <= req_data_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         cur_ff      <= '0;
         prev_ff     <= '0;
         fire_now_ff <= 1'b0;
      end else if (stage_go) begin
         held_ff <= held_in;
         if (req_op_ff == OP_FRAME_TICK) begin
            prev_ff     <= cur_ff;
            cur_ff      <= held_ff;
            fire_now_ff <= fire_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_go && has_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && stage_go && has_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_key_press_sets: assert property (@(posedge clock) disable iff (reset)
      (stage_go && req_op_ff == OP_KEY_EVENT && key_ok && !req_ff.key_released)
      |=> held_ff[$past(key_idx)])
      else $error("key press did not set held entry");

   a_tick_shifts_snapshots: assert property (@(posedge clock) disable iff (reset)
      (stage_go && req_op_ff == OP_FRAME_TICK)
      |=> (cur_ff == $past(held_ff)) && (prev_ff == $past(cur_ff)))
      else $error("frame tick snapshot shift wrong");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !stage_go) |=> req_valid_ff && $stable(req_ff) && $stable(req_op_ff))
      else $error("stalled request stage changed");

   a_no_state_change_idle: assert property (@(posedge clock) disable iff (reset)
      !stage_go |=> $stable(held_ff) && $stable(cur_ff) && $stable(fire_now_ff))
      else $error("key state changed without a request");
`endif

endmodule
